// ----- rtl/core/swfc_pkg.sv -----
`default_nettype none

package swfc_pkg;

  // Sample geometry
  localparam int MAX_SAMPLE_BYTES = 8;
  localparam int WORD_BYTES       = 8;
  localparam int WORD_W           = 8 * WORD_BYTES;

  // Configuration port geometry
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 7;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_BYTES  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_VALID_BITS    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHIFT_AMOUNT  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BIG_ENDIAN    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIGNED_SAMPLE = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_FULLY_DEFINED = 3'd5;

  // Transfer direction codes
  localparam logic MODE_UNPACK = 1'b0;
  localparam logic MODE_PACK   = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/core/sample_word_format_converter_top.sv -----
// Sample word format converter.
// Input channel: mode_i and word_in_i with in_valid_i / in_stall_o. Mode unpack turns a
// device sample word (byte 0 in bits 7..0) into a host value; mode pack does the reverse.
// Output channel: word_out_o with out_valid_o / out_stall_i. Bytes beyond the sample
// width are always zero.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i. cfg_ready_o
// is always high; write only while no transfer is in flight.
// An accepted word passes the input register and then the result register before it
// appears on the output; an out_stall_i stall can hold it in the input register.
// Throughput: one word per cycle while out_stall_i is low. The byte swap, barrel shift
// and mask all sit in one combinational stage between the input and result registers.
// Reset clears both stage valid flags and loads the register defaults: 2-byte samples,
// 16 valid bits, no shift, little-endian, unsigned, not fully defined.
// When out_stall_i holds the result, the input register still takes one more word; with
// both stages full, in_stall_o rises until the result is taken.
`default_nettype none

module sample_word_format_converter_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // input channel
  input  wire logic                                in_valid_i,
  output      logic                                in_stall_o,
  input  wire logic                                mode_i,
  input  wire logic [swfc_pkg::WORD_W-1:0]         word_in_i,
  // output channel
  output      logic                                out_valid_o,
  input  wire logic                                out_stall_i,
  output      logic [swfc_pkg::WORD_W-1:0]         word_out_o,
  // configuration channel
  input  wire logic                                cfg_valid_i,
  output      logic                                cfg_ready_o,
  input  wire logic [swfc_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  wire logic [swfc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int WordW  = swfc_pkg::WORD_W;
  localparam int WordB  = swfc_pkg::WORD_BYTES;

  // Configuration registers
  logic [3:0] sample_bytes_q;
  logic [6:0] valid_bits_q;
  logic [5:0] shift_amount_q;
  logic       big_endian_q;
  logic       signed_sample_q;
  logic       fully_defined_q;

  // Pipeline registers
  logic             s1_valid_q, s1_valid_d;
  logic             s1_mode_q;
  logic [WordW-1:0] s1_word_q;
  logic             out_valid_q, out_valid_d;
  logic [WordW-1:0] out_word_q;

  logic             in_acc;
  logic             s2_take;
  logic             cfg_we;

  // Datapath signals
  logic [3:0]       nbytes;
  logic [6:0]       wbits;
  logic [6:0]       vbits;
  logic [WordW-1:0] wmask;
  logic [WordW-1:0] vmask;
  logic             swap;
  logic             large_shift;
  logic [WordW-1:0] v0;
  logic [WordW-1:0] rev_in;
  logic [WordW-1:0] rev_out;
  logic [WordW-1:0] u_shr;
  logic             u_top;
  logic [WordW-1:0] u_res;
  logic [WordW-1:0] p_shl;
  logic [WordW-1:0] p_res;
  logic [WordW-1:0] result;

  // Handshake
  assign s2_take     = !out_valid_q || !out_stall_i;
  assign in_stall_o  = s1_valid_q && !s2_take;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign s1_valid_d  = in_acc ? 1'b1 : (s2_take ? 1'b0 : s1_valid_q);
  assign out_valid_d = s2_take ? s1_valid_q : out_valid_q;
  assign out_valid_o = out_valid_q;
  assign word_out_o  = out_word_q;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_bytes_q  <= 4'd2;
      valid_bits_q    <= 7'd16;
      shift_amount_q  <= 6'd0;
      big_endian_q    <= 1'b0;
      signed_sample_q <= 1'b0;
      fully_defined_q <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        swfc_pkg::CFG_SAMPLE_BYTES:  sample_bytes_q  <= cfg_data_i[3:0];
        swfc_pkg::CFG_VALID_BITS:    valid_bits_q    <= cfg_data_i[6:0];
        swfc_pkg::CFG_SHIFT_AMOUNT:  shift_amount_q  <= cfg_data_i[5:0];
        swfc_pkg::CFG_BIG_ENDIAN:    big_endian_q    <= cfg_data_i[0];
        swfc_pkg::CFG_SIGNED_SAMPLE: signed_sample_q <= cfg_data_i[0];
        swfc_pkg::CFG_FULLY_DEFINED: fully_defined_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_mode_q <= mode_i;
      s1_word_q <= word_in_i;
    end
    if (s2_take && s1_valid_q) begin
      out_word_q <= result;
    end
  end

  // Derive sample geometry from the configuration
  always_comb begin
    if (sample_bytes_q == 4'd0) begin
      nbytes = 4'd1;
    end else if (sample_bytes_q > 4'(swfc_pkg::MAX_SAMPLE_BYTES)) begin
      nbytes = 4'(swfc_pkg::MAX_SAMPLE_BYTES);
    end else begin
      nbytes = sample_bytes_q;
    end
    wbits = {nbytes, 3'b000};
    for (int i = 0; i < WordB; i++) begin
      wmask[i*8 +: 8] = (4'(i) < nbytes) ? 8'hff : 8'h00;
    end
    vbits       = (valid_bits_q > wbits) ? wbits : valid_bits_q;
    vmask       = ~({WordW{1'b1}} << vbits);
    swap        = big_endian_q && (nbytes > 4'd1);
    large_shift = {1'b0, shift_amount_q} >= wbits;
  end

  // Shared byte reorder: device word on unpack, shifted value on pack
  always_comb begin
    v0     = s1_word_q & wmask;
    p_shl  = large_shift ? '0 : (((v0 & vmask) << shift_amount_q) & wmask);
    rev_in = (s1_mode_q == swfc_pkg::MODE_PACK) ? p_shl : v0;
    for (int j = 0; j < WordB; j++) begin
      if (4'(j) < nbytes) begin
        rev_out[j*8 +: 8] = rev_in[8*(3'(nbytes - 4'd1 - 4'(j))) +: 8];
      end else begin
        rev_out[j*8 +: 8] = 8'h00;
      end
    end
  end

  // Unpack: shift down, then sign-extend, mask or pass when fully defined; pick pack or unpack
  always_comb begin
    u_shr = large_shift ? '0 : ((swap ? rev_out : v0) >> shift_amount_q);
    u_top = (vbits != 7'd0) && u_shr[6'(vbits - 7'd1)];
    if (fully_defined_q) begin
      u_res = u_shr;
    end else if (signed_sample_q && u_top) begin
      u_res = (u_shr | ~vmask) & wmask;
    end else begin
      u_res = u_shr & vmask;
    end
    p_res  = swap ? rev_out : p_shl;
    result = ((s1_mode_q == swfc_pkg::MODE_PACK) ? p_res : u_res) & wmask;
  end

endmodule

`default_nettype wire

// ----- rtl/core/swfc_checker.sv -----
`default_nettype none

module swfc_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_stall_o,
  input wire logic                              mode_i,
  input wire logic [swfc_pkg::WORD_W-1:0]       word_in_i,
  input wire logic                              out_valid_o,
  input wire logic                              out_stall_i,
  input wire logic [swfc_pkg::WORD_W-1:0]       word_out_o,
  input wire logic                              cfg_valid_i,
  input wire logic                              cfg_ready_o,
  input wire logic [swfc_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input wire logic [swfc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  logic in_xfer;
  logic unused_inputs;

  assign in_xfer       = in_valid_i && !in_stall_o;
  assign unused_inputs = ^{mode_i, word_in_i, cfg_valid_i, cfg_ready_o, cfg_index_i,
                           cfg_data_i};

  // A held result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(word_out_o))
    else $error("stalled result changed or dropped");

  // The result register only empties through a transfer
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("result dropped without transfer");

  // Input only backs up when a result is waiting
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with output free");

  // An accepted word is followed by a valid result on the output
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> ##1 out_valid_o)
    else $error("accepted word did not reach the output");

endmodule

bind sample_word_format_converter_top swfc_checker u_swfc_checker (.*);

`default_nettype wire
